// File: sv/poe_pkg.sv
package poe_pkg;

    // Default element capacity; the element field limits use to 16.
    localparam int NODES_DEF = 16;
    localparam int MAX_IDX = 16;

    localparam logic [4:0] NODE_COUNT_RST = 5'd16;

    // Operation codes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_QUERY = 3'd1;
    localparam logic [2:0] OP_JOIN  = 3'd2;
    localparam logic [2:0] OP_MEET  = 3'd3;
    localparam logic [2:0] OP_MAX   = 3'd4;
    localparam logic [2:0] OP_MIN   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_TRUE  = 2'd0;
    localparam logic [1:0] ST_FALSE = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [3:0] {
        DP_NOP       = 4'd0,
        DP_LOAD      = 4'd1,
        DP_ERR       = 4'd2,
        DP_ADD       = 4'd3,
        DP_SEED_X    = 4'd4,
        DP_SEED_Y    = 4'd5,
        DP_REACH     = 4'd6,
        DP_QUERY     = 4'd7,
        DP_ENT_INIT  = 4'd8,
        DP_ENT       = 4'd9,
        DP_JOIN      = 4'd10,
        DP_SCAN_INIT = 4'd11,
        DP_SCAN      = 4'd12,
        DP_EMIT      = 4'd13
    } dp_op_t;

    typedef struct packed {
        dp_op_t code;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       range_err;
        logic       n_zero;
        logic       cnt_last;
        logic       chg_any;
        logic       list_last;
    } stat_t;

endpackage

// File: sv/poe_dp.sv
module poe_dp #(
    parameter int NODES = poe_pkg::NODES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  poe_pkg::cmd_t       cmd,
    output poe_pkg::stat_t      stat,
    input  logic [2:0]          op_in,
    input  logic [3:0]          x_in,
    input  logic [3:0]          y_in,
    input  logic                cfg_we,
    input  logic [4:0]          cfg_data,
    output logic                res_valid,
    output logic [1:0]          res_status,
    output logic [3:0]          res_element,
    output logic                res_last
);

    localparam int ROWS = (NODES < poe_pkg::MAX_IDX) ? NODES : poe_pkg::MAX_IDX;
    localparam int IW   = $clog2(ROWS);
    localparam int NW   = $clog2(ROWS + 1);

    logic [4:0]      nc_reg;
    logic [ROWS-1:0] mat_reg [ROWS];

    logic [2:0]      op_reg,   op_next;
    logic [3:0]      x_reg,    x_next;
    logic [3:0]      y_reg,    y_next;
    logic [IW-1:0]   cnt_reg,  cnt_next;
    logic [ROWS-1:0] seen_reg, seen_next;
    logic [ROWS-1:0] a_reg,    a_next;
    logic [ROWS-1:0] vec_reg,  vec_next;
    logic [ROWS-1:0] list_reg, list_next;
    logic            chg_reg,  chg_next;
    logic            rv_reg,   rv_next;
    logic [1:0]      st_reg,   st_next;
    logic [3:0]      el_reg,   el_next;
    logic            last_reg, last_next;

    logic [NW-1:0]   n_eff;
    logic [ROWS-1:0] mask;
    logic [IW-1:0]   rd_idx;
    logic [ROWS-1:0] row;
    logic [ROWS-1:0] cnt_bit;
    logic            rev;
    logic            cnt_last;
    logic [ROWS-1:0] reach_new;
    logic            changed;
    logic [ROWS-1:0] ent_new;
    logic [ROWS-1:0] scan_new;
    logic [ROWS-1:0] cand;
    logic [IW-1:0]   cand_idx;
    logic [IW-1:0]   list_idx;
    logic [ROWS-1:0] list_clr;
    logic            add_we;

    assign n_eff = (nc_reg > 5'(ROWS)) ? NW'(ROWS) : nc_reg[NW-1:0];

    always_comb
    begin
        for (int i = 0; i < ROWS; i++)
        begin
            mask[i] = (i < int'(n_eff));
        end
    end

    assign rev      = (op_reg == poe_pkg::OP_MEET) || (op_reg == poe_pkg::OP_MIN);
    assign rd_idx   = (cmd.code == poe_pkg::DP_ADD) ? x_reg[IW-1:0] : cnt_reg;
    assign row      = mat_reg[rd_idx] & mask;
    assign cnt_bit  = ROWS'(1) << cnt_reg;
    assign cnt_last = ((NW+1)'(cnt_reg) + (NW+1)'(1)) == (NW+1)'(n_eff);

    // One matrix row per cycle: forward follows row cnt out of a seen
    // element, reverse marks cnt when its row hits the seen set.
    always_comb
    begin
        if (!rev)
        begin
            reach_new = seen_reg[cnt_reg] ? (seen_reg | row) : seen_reg;
        end
        else
        begin
            reach_new = (|(row & seen_reg)) ? (seen_reg | cnt_bit) : seen_reg;
        end
    end
    assign changed = (reach_new != seen_reg);

    // a_reg holds the common upper (or lower) set during the entry scan.
    always_comb
    begin
        ent_new = vec_reg;
        if (a_reg[cnt_reg])
        begin
            if (!rev)
            begin
                ent_new = vec_reg | (row & ~cnt_bit);
            end
            else if (|(row & a_reg & ~cnt_bit))
            begin
                ent_new = vec_reg | cnt_bit;
            end
        end
    end

    // Forward: mark empty rows. Reverse: collect columns that have a bit.
    always_comb
    begin
        if (!rev)
        begin
            scan_new = (row == '0) ? (vec_reg | cnt_bit) : vec_reg;
        end
        else
        begin
            scan_new = vec_reg | row;
        end
    end

    assign cand = a_reg & ~vec_reg;

    always_comb
    begin
        cand_idx = '0;
        list_idx = '0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                cand_idx = IW'(i);
            end
            if (list_reg[i])
            begin
                list_idx = IW'(i);
            end
        end
    end
    assign list_clr = list_reg & ~(ROWS'(1) << list_idx);

    assign add_we = (cmd.code == poe_pkg::DP_ADD) && (x_reg != y_reg) &&
                    !row[y_reg[IW-1:0]];

    always_comb
    begin
        op_next   = op_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        seen_next = seen_reg;
        a_next    = a_reg;
        vec_next  = vec_reg;
        list_next = list_reg;
        chg_next  = chg_reg;
        rv_next   = 1'b0;
        st_next   = st_reg;
        el_next   = el_reg;
        last_next = last_reg;
        case (cmd.code)
            poe_pkg::DP_LOAD:
            begin
                op_next = op_in;
                x_next  = x_in;
                y_next  = y_in;
            end
            poe_pkg::DP_ERR:
            begin
                rv_next   = 1'b1;
                st_next   = poe_pkg::ST_RANGE;
                el_next   = 4'd0;
                last_next = 1'b1;
            end
            poe_pkg::DP_ADD:
            begin
                rv_next   = 1'b1;
                st_next   = add_we ? poe_pkg::ST_TRUE : poe_pkg::ST_FALSE;
                el_next   = 4'd0;
                last_next = 1'b1;
            end
            poe_pkg::DP_SEED_X:
            begin
                seen_next = ROWS'(1) << x_reg[IW-1:0];
                cnt_next  = '0;
                chg_next  = 1'b0;
            end
            poe_pkg::DP_SEED_Y:
            begin
                a_next    = seen_reg;
                seen_next = ROWS'(1) << y_reg[IW-1:0];
                cnt_next  = '0;
                chg_next  = 1'b0;
            end
            poe_pkg::DP_REACH:
            begin
                seen_next = reach_new;
                if (cnt_last)
                begin
                    cnt_next = '0;
                    chg_next = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                    chg_next = chg_reg | changed;
                end
            end
            poe_pkg::DP_QUERY:
            begin
                rv_next   = 1'b1;
                st_next   = seen_reg[y_reg[IW-1:0]] ? poe_pkg::ST_TRUE : poe_pkg::ST_FALSE;
                el_next   = 4'd0;
                last_next = 1'b1;
            end
            poe_pkg::DP_ENT_INIT:
            begin
                a_next   = a_reg & seen_reg;
                vec_next = '0;
                cnt_next = '0;
            end
            poe_pkg::DP_ENT:
            begin
                vec_next = ent_new;
                cnt_next = cnt_last ? '0 : cnt_reg + IW'(1);
            end
            poe_pkg::DP_JOIN:
            begin
                rv_next   = 1'b1;
                last_next = 1'b1;
                if ((cand != '0) && ((cand & (cand - ROWS'(1))) == '0))
                begin
                    st_next = poe_pkg::ST_TRUE;
                    el_next = 4'(cand_idx);
                end
                else
                begin
                    st_next = poe_pkg::ST_FALSE;
                    el_next = 4'd0;
                end
            end
            poe_pkg::DP_SCAN_INIT:
            begin
                vec_next  = '0;
                list_next = '0;
                cnt_next  = '0;
            end
            poe_pkg::DP_SCAN:
            begin
                vec_next = scan_new;
                cnt_next = cnt_last ? '0 : cnt_reg + IW'(1);
                if (cnt_last)
                begin
                    list_next = rev ? (mask & ~scan_new) : scan_new;
                end
            end
            poe_pkg::DP_EMIT:
            begin
                rv_next = 1'b1;
                if (list_reg == '0)
                begin
                    st_next   = poe_pkg::ST_FALSE;
                    el_next   = 4'd0;
                    last_next = 1'b1;
                end
                else
                begin
                    st_next   = poe_pkg::ST_TRUE;
                    el_next   = 4'(list_idx);
                    last_next = (list_clr == '0);
                    list_next = list_clr;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg <= poe_pkg::NODE_COUNT_RST;
            rv_reg <= 1'b0;
            for (int i = 0; i < ROWS; i++)
            begin
                mat_reg[i] <= '0;
            end
        end
        else
        begin
            rv_reg <= rv_next;
            if (cfg_we)
            begin
                nc_reg <= cfg_data;
            end
            if (add_we)
            begin
                mat_reg[x_reg[IW-1:0]][y_reg[IW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        cnt_reg  <= cnt_next;
        seen_reg <= seen_next;
        a_reg    <= a_next;
        vec_reg  <= vec_next;
        list_reg <= list_next;
        chg_reg  <= chg_next;
        st_reg   <= st_next;
        el_reg   <= el_next;
        last_reg <= last_next;
    end

    assign stat.op        = op_reg;
    assign stat.range_err = ({1'b0, x_reg} >= 5'(n_eff)) || ({1'b0, y_reg} >= 5'(n_eff));
    assign stat.n_zero    = (n_eff == '0);
    assign stat.cnt_last  = cnt_last;
    assign stat.chg_any   = chg_reg | changed;
    assign stat.list_last = ((list_reg & (list_reg - ROWS'(1))) == '0);

    assign res_valid   = rv_reg;
    assign res_status  = st_reg;
    assign res_element = el_reg;
    assign res_last    = last_reg;

endmodule

// File: sv/poe_ctrl.sv
module poe_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  poe_pkg::stat_t stat,
    output poe_pkg::cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_REACH = 8'b0000_0100,
        S_RNEXT = 8'b0000_1000,
        S_ENTER = 8'b0001_0000,
        S_JOIN  = 8'b0010_0000,
        S_SCAN  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd.code   = poe_pkg::DP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.code   = poe_pkg::DP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                phase_next = 1'b0;
                if (stat.op > poe_pkg::OP_MIN)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.op == poe_pkg::OP_MAX || stat.op == poe_pkg::OP_MIN)
                begin
                    cmd.code   = poe_pkg::DP_SCAN_INIT;
                    state_next = stat.n_zero ? S_EMIT : S_SCAN;
                end
                else if (stat.range_err)
                begin
                    cmd.code   = poe_pkg::DP_ERR;
                    state_next = S_IDLE;
                end
                else if (stat.op == poe_pkg::OP_ADD)
                begin
                    cmd.code   = poe_pkg::DP_ADD;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.code   = poe_pkg::DP_SEED_X;
                    state_next = S_REACH;
                end
            end
            S_REACH:
            begin
                cmd.code = poe_pkg::DP_REACH;
                if (stat.cnt_last && !stat.chg_any)
                begin
                    state_next = S_RNEXT;
                end
            end
            S_RNEXT:
            begin
                if (stat.op == poe_pkg::OP_QUERY)
                begin
                    cmd.code   = poe_pkg::DP_QUERY;
                    state_next = S_IDLE;
                end
                else if (!phase_reg)
                begin
                    cmd.code   = poe_pkg::DP_SEED_Y;
                    phase_next = 1'b1;
                    state_next = S_REACH;
                end
                else
                begin
                    cmd.code   = poe_pkg::DP_ENT_INIT;
                    state_next = S_ENTER;
                end
            end
            S_ENTER:
            begin
                cmd.code = poe_pkg::DP_ENT;
                if (stat.cnt_last)
                begin
                    state_next = S_JOIN;
                end
            end
            S_JOIN:
            begin
                cmd.code   = poe_pkg::DP_JOIN;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.code = poe_pkg::DP_SCAN;
                if (stat.cnt_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.code = poe_pkg::DP_EMIT;
                if (stat.list_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: sv/poset_order_engine.sv
// Sequencing: add and index errors strobe from the check state through the result register.
//   A query runs reachability passes over the n active rows (n = active count, at most n
//   passes), then strobes its answer; join and meet run two such closures plus an entry scan
//   of the n rows; maximal/minimal take a scan of the n rows, then one result per cycle.
// Throughput: one item at a time; busy drops in the cycle the last result is shown.
// Reset: relation matrix cleared, node_count = 16; results cannot be stalled.
module poset_order_engine #(
    parameter int NODES = poe_pkg::NODES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // command channel
    input  logic       start,
    output logic       busy,
    input  logic [2:0] op,
    input  logic [3:0] first_element,
    input  logic [3:0] second_element,
    // node_count register write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data,
    // result items, one cycle each
    output logic       result_valid,
    output logic [1:0] status,
    output logic [3:0] element,
    output logic       last
);

    // The controller sequences the datapath; the datapath owns the relation
    // matrix (flops, async cleared), the frontier/common vectors and the
    // result register. A single row-read index walks the matrix each cycle.
    poe_pkg::cmd_t  cmd;
    poe_pkg::stat_t stat;

    // Users must land configuration only while idle, unenforced; the write is always taken.
    assign cfg_ready = 1'b1;

    poe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    poe_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .op_in       (op),
        .x_in        (first_element),
        .y_in        (second_element),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_data    (cfg_data),
        .res_valid   (result_valid),
        .res_status  (status),
        .res_element (element),
        .res_last    (last)
    );

`ifndef SYNTH
    // An accepted item always occupies the engine for the next cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after accepting an item");

    // Final result coincides with the return to idle; earlier ones do not.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("busy still high on final result");

    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("idle while results are still pending");

    // Only a found or listed element carries an index.
    a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != poe_pkg::ST_TRUE) |-> (element == 4'd0))
        else $error("nonzero element on a negative result");
`endif

endmodule

// File: test/poset_order_engine_test.sv
typedef struct packed {
    logic [1:0] status;
    logic [3:0] element;
    logic       last;
} order_result_t;

// Tracks the stored relations and node_count alongside the block and keeps the
// results every accepted command must still produce, oldest first.
class order_tracker;
    logic [15:0]   relation [16];
    logic [15:0]   view_rows [16];
    logic [4:0]    node_count;
    order_result_t pending_results [$];
    int unsigned   items_noted;
    int unsigned   results_checked;
    int unsigned   mismatches;
    int unsigned   op_seen [8];

    function new();
        foreach (relation[i])
        begin
            relation[i] = '0;
        end
        foreach (op_seen[i])
        begin
            op_seen[i] = 0;
        end
        node_count = poe_pkg::NODE_COUNT_RST;
        items_noted = 0;
        results_checked = 0;
        mismatches = 0;
    endfunction

    function int active_count();
        int n;
        n = node_count;
        if (n > 16)
        begin
            n = 16;
        end
        return n;
    endfunction

    function int pending_count();
        return pending_results.size();
    endfunction

    // Rows of the elements in use, masked; transposed for meet and minimal.
    function void load_view(bit reversed, int n);
        logic [15:0] mask;
        logic [15:0] r;
        mask = (n >= 16) ? 16'hffff : ((16'd1 << n) - 16'd1);
        foreach (view_rows[i])
        begin
            view_rows[i] = '0;
        end
        for (int i = 0; i < n; i++)
        begin
            r = relation[i] & mask;
            if (!reversed)
            begin
                view_rows[i] = r;
            end
            else
            begin
                for (int j = 0; j < n; j++)
                begin
                    if (r[j])
                    begin
                        view_rows[j][i] = 1'b1;
                    end
                end
            end
        end
    endfunction

    // Closure of the frontier over the loaded rows.
    function logic [15:0] reach_from(int n, logic [3:0] origin);
        logic [15:0] seen;
        logic [15:0] prev;
        seen = 16'd1 << origin;
        prev = '0;
        while (seen != prev)
        begin
            prev = seen;
            for (int i = 0; i < n; i++)
            begin
                if (prev[i])
                begin
                    seen = seen | view_rows[i];
                end
            end
        end
        return seen;
    endfunction

    function void push_result(logic [1:0] st, logic [3:0] el, logic fin);
        order_result_t r;
        r.status = st;
        r.element = el;
        r.last = fin;
        pending_results = {pending_results, r};
    endfunction

    function void note_command(logic [2:0] op, logic [3:0] x, logic [3:0] y);
        int n;
        int found;
        int which;
        int last_listed;
        bit entered;
        logic [15:0] common;
        logic [15:0] from_x;
        items_noted++;
        op_seen[op]++;
        n = active_count();
        if (op <= poe_pkg::OP_MEET)
        begin
            if (x >= n || y >= n)
            begin
                push_result(poe_pkg::ST_RANGE, 4'd0, 1'b1);
            end
            else if (op == poe_pkg::OP_ADD)
            begin
                if (x == y || relation[x][y])
                begin
                    push_result(poe_pkg::ST_FALSE, 4'd0, 1'b1);
                end
                else
                begin
                    relation[x][y] = 1'b1;
                    push_result(poe_pkg::ST_TRUE, 4'd0, 1'b1);
                end
            end
            else
            begin
                load_view(op == poe_pkg::OP_MEET, n);
                from_x = reach_from(n, x);
                if (op == poe_pkg::OP_QUERY)
                begin
                    push_result(from_x[y] ? poe_pkg::ST_TRUE : poe_pkg::ST_FALSE,
                                4'd0, 1'b1);
                end
                else
                begin
                    // keep common bounds with no relation entering from another one
                    common = from_x & reach_from(n, y);
                    found = 0;
                    which = 0;
                    for (int i = 0; i < n; i++)
                    begin
                        if (common[i])
                        begin
                            entered = 1'b0;
                            for (int j = 0; j < n; j++)
                            begin
                                if (j != i && common[j] && view_rows[j][i])
                                begin
                                    entered = 1'b1;
                                end
                            end
                            if (!entered)
                            begin
                                found++;
                                which = i;
                            end
                        end
                    end
                    if (found == 1)
                    begin
                        push_result(poe_pkg::ST_TRUE, which[3:0], 1'b1);
                    end
                    else
                    begin
                        push_result(poe_pkg::ST_FALSE, 4'd0, 1'b1);
                    end
                end
            end
        end
        else if (op == poe_pkg::OP_MAX || op == poe_pkg::OP_MIN)
        begin
            load_view(op == poe_pkg::OP_MIN, n);
            last_listed = -1;
            for (int i = 0; i < n; i++)
            begin
                if (view_rows[i] == '0)
                begin
                    last_listed = i;
                end
            end
            if (last_listed < 0)
            begin
                push_result(poe_pkg::ST_FALSE, 4'd0, 1'b1);
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (view_rows[i] == '0)
                    begin
                        push_result(poe_pkg::ST_TRUE, i[3:0], i == last_listed);
                    end
                end
            end
        end
        // spare op codes: no result, no change
    endfunction

    function void check_result(logic [1:0] got_status, logic [3:0] got_element,
                               logic got_last);
        order_result_t want;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected result: status %0d element %0d last %0d",
                         got_status, got_element, got_last);
            end
        end
        else
        begin
            want = pending_results.pop_front();
            results_checked++;
            if (want.status !== got_status || want.element !== got_element ||
                want.last !== got_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: want st %0d el %0d last %0d, got st %0d el %0d last %0d",
                             want.status, want.element, want.last,
                             got_status, got_element, got_last);
                end
            end
        end
    endfunction
endclass

module poset_order_engine_test;

    // Op codes the block must ignore without a result.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Worst case per command is roughly two closures of up to n passes over the n
    // rows plus a scan, at 16 elements.
    localparam int SETTLE_CYCLES = 600;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEMS_PER_CHUNK = 20;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [2:0] op = '0;
    logic [3:0] first_element = '0;
    logic [3:0] second_element = '0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_data = '0;
    logic       result_valid;
    logic [1:0] status;
    logic [3:0] element;
    logic       last;

    order_tracker tracker;
    int cycle_count = 0;
    int config_writes = 0;

    poset_order_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .first_element  (first_element),
        .second_element (second_element),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .status         (status),
        .element        (element),
        .last           (last)
    );

    always #5 clk = ~clk;

    // Results cannot be held off: every strobe is checked at the edge ending it.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            tracker.check_result(status, element, last);
        end
    end

    // Hard stop if the block hangs or drops results.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("poset_order_engine verification failed");
            $finish;
        end
    end

    // Present one command and hold it until the block takes it. The command is
    // taken at the edge where start is high and busy is low. Afterwards start
    // either stays high for the next command or drops for a random gap.
    task automatic issue_command(logic [2:0] op_v, logic [3:0] x_v, logic [3:0] y_v,
                                 int gap_pct);
        op <= op_v;
        first_element <= x_v;
        second_element <= y_v;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        tracker.note_command(op_v, x_v, y_v);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic pause_until_drained();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending_count() != 0 || busy)
        begin
            @(posedge clk);
        end
    endtask

    // node_count changes only while idle; the extra pad covers a spare op
    // that may still be in flight with nothing left to expect.
    task automatic write_node_count(logic [4:0] value);
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        tracker.node_count = value;
        config_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Mostly in-range commands so adds build up real orders for the queries,
    // joins and meets; a tenth use any index to hit the range check.
    task automatic random_command(int gap_pct);
        int n;
        int pick;
        logic [2:0] op_v;
        logic [3:0] x_v;
        logic [3:0] y_v;
        n = tracker.active_count();
        pick = $urandom_range(99);
        if (pick < 36)
        begin
            op_v = poe_pkg::OP_ADD;
        end
        else if (pick < 52)
        begin
            op_v = poe_pkg::OP_QUERY;
        end
        else if (pick < 66)
        begin
            op_v = poe_pkg::OP_JOIN;
        end
        else if (pick < 80)
        begin
            op_v = poe_pkg::OP_MEET;
        end
        else if (pick < 89)
        begin
            op_v = poe_pkg::OP_MAX;
        end
        else if (pick < 97)
        begin
            op_v = poe_pkg::OP_MIN;
        end
        else
        begin
            op_v = ($urandom_range(1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
        end
        if (n > 0 && $urandom_range(9) != 0)
        begin
            x_v = $urandom_range(n - 1);
            y_v = $urandom_range(n - 1);
        end
        else
        begin
            x_v = $urandom_range(15);
            y_v = $urandom_range(15);
        end
        // now and then let the block run completely dry
        if ($urandom_range(39) == 0)
        begin
            pause_until_drained();
        end
        issue_command(op_v, x_v, y_v, gap_pct);
    endtask

    int gap_plan [3] = '{32, 69, 0};
    logic [4:0] count_plan [9] = '{5'd5, 5'd16, 5'd2, 5'd8, 5'd31, 5'd3, 5'd1, 5'd12, 5'd4};

    initial
    begin
        tracker = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, full count of 16: empty order lists every element
        issue_command(poe_pkg::OP_MAX, 4'd0, 4'd0, 0);
        issue_command(poe_pkg::OP_MIN, 4'd0, 4'd0, 0);
        // stored add, repeated add, add to itself
        issue_command(poe_pkg::OP_ADD, 4'd0, 4'd1, 0);
        issue_command(poe_pkg::OP_ADD, 4'd0, 4'd1, 0);
        issue_command(poe_pkg::OP_ADD, 4'd3, 4'd3, 0);
        issue_command(poe_pkg::OP_ADD, 4'd1, 4'd15, 0);
        issue_command(poe_pkg::OP_ADD, 4'd2, 4'd15, 0);
        // transitive, reversed and reflexive queries
        issue_command(poe_pkg::OP_QUERY, 4'd0, 4'd15, 0);
        issue_command(poe_pkg::OP_QUERY, 4'd15, 4'd0, 0);
        issue_command(poe_pkg::OP_QUERY, 4'd5, 4'd5, 0);
        // join and meet with an answer, then with none
        issue_command(poe_pkg::OP_JOIN, 4'd0, 4'd2, 0);
        issue_command(poe_pkg::OP_MEET, 4'd15, 4'd1, 0);
        issue_command(poe_pkg::OP_JOIN, 4'd3, 4'd4, 0);
        // spare op codes produce nothing
        issue_command(OP_SPARE_LO, 4'd7, 4'd8, 0);
        issue_command(OP_SPARE_HI, 4'd15, 4'd15, 0);
        // close a cycle 0 -> 1 -> 15 -> 0 and list around it
        issue_command(poe_pkg::OP_ADD, 4'd15, 4'd0, 0);
        issue_command(poe_pkg::OP_MAX, 4'd0, 4'd0, 0);
        issue_command(poe_pkg::OP_MIN, 4'd0, 4'd0, 0);

        // shrunk count: indexes past it are out of range, relations kept
        write_node_count(5'd4);
        issue_command(poe_pkg::OP_QUERY, 4'd5, 4'd0, 0);
        issue_command(poe_pkg::OP_ADD, 4'd0, 4'd9, 0);
        issue_command(poe_pkg::OP_JOIN, 4'd2, 4'd7, 0);
        issue_command(poe_pkg::OP_MEET, 4'd9, 4'd9, 0);

        // two elements with only 0 -> 1 left: element 1 alone is maximal
        write_node_count(5'd2);
        issue_command(poe_pkg::OP_MAX, 4'd0, 4'd0, 0);

        // no elements at all
        write_node_count(5'd0);
        issue_command(poe_pkg::OP_MIN, 4'd0, 4'd0, 0);
        issue_command(poe_pkg::OP_QUERY, 4'd0, 4'd0, 0);

        // Random part: three sender phases, each split into chunks with a
        // fresh node_count; the last phase sends back to back.
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int chunk = 0; chunk < 3; chunk++)
            begin
                write_node_count(count_plan[phase * 3 + chunk]);
                for (int k = 0; k < ITEMS_PER_CHUNK + (chunk == 0 ? 1 : 0); k++)
                begin
                    random_command(gap_plan[phase]);
                end
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending_count() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d commands (add %0d, query %0d, join %0d, meet %0d,",
                 tracker.items_noted, tracker.op_seen[poe_pkg::OP_ADD],
                 tracker.op_seen[poe_pkg::OP_QUERY], tracker.op_seen[poe_pkg::OP_JOIN],
                 tracker.op_seen[poe_pkg::OP_MEET]);
        $display("  max %0d, min %0d, spare %0d), %0d results over %0d node_count writes",
                 tracker.op_seen[poe_pkg::OP_MAX], tracker.op_seen[poe_pkg::OP_MIN],
                 tracker.op_seen[OP_SPARE_LO] + tracker.op_seen[OP_SPARE_HI],
                 tracker.results_checked, config_writes);
        if (tracker.mismatches == 0 && tracker.pending_count() == 0)
        begin
            $display("poset_order_engine verification clean");
        end
        else
        begin
            $display("poset_order_engine verification failed");
        end
        $finish;
    end

endmodule
